// File: sv/assert_macros.svh
// Assertion macros shared by the duty calculator RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check, disabled while reset is asserted.
`define SVPWM_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("svpwm: assertion failed");

// Same-cycle implication, disabled while reset is asserted.
`define SVPWM_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("svpwm: implication failed");

`endif

// File: sv/svpwm_pkg.sv
// Shared constants, sideband types and sector lookup for the SVPWM duty calculator.
// No dependencies.
package svpwm_pkg;

	localparam logic [16:0] SQRT3_Q16      = 17'd113512;
	localparam logic [15:0] SQRT3_HALF_Q16 = 16'd56756;
	localparam logic [17:0] Q16_ONE        = 18'd65536;
	localparam logic [15:0] HALF_Q15       = 16'd16384;

	localparam logic [15:0] MOD_LIMIT_RST = 16'd31130;
	localparam logic [15:0] MIN_BUS_RST   = 16'd26;

	localparam int APB_AW = 3;
	localparam logic [APB_AW-1:0] ADDR_MOD_LIMIT = 3'd0;
	localparam logic [APB_AW-1:0] ADDR_MIN_BUS   = 3'd4;

	localparam logic [2:0] SECTOR_NONE = 3'd0;
	localparam logic [2:0] SECTOR_1    = 3'd1;
	localparam logic [2:0] SECTOR_2    = 3'd2;
	localparam logic [2:0] SECTOR_3    = 3'd3;
	localparam logic [2:0] SECTOR_4    = 3'd4;
	localparam logic [2:0] SECTOR_5    = 3'd5;
	localparam logic [2:0] SECTOR_6    = 3'd6;

	// sideband through the normalizing divider
	typedef struct packed {
		logic bus_low;
		logic neg_a;
		logic neg_b;
	} side_a_t;

	// sideband through the unit-sum rescale divider
	typedef struct packed {
		logic        big;
		logic [16:0] t1;
		logic [16:0] t2;
		logic [2:0]  sector;
		logic        bus_low;
	} side_b_t;

	// sideband through the modulation-limit divider
	typedef struct packed {
		logic        big;
		logic [16:0] t1;
		logic [16:0] t2;
		logic [2:0]  sector;
		logic        bus_low;
	} side_c_t;

	// projection sign code {u3>0, u2>0, u1>0} to sector
	function automatic logic [2:0] sector_of_code(input logic [2:0] code);
		logic [2:0] s;
		unique case (code)
			3'd1: s = SECTOR_2;
			3'd2: s = SECTOR_6;
			3'd3: s = SECTOR_1;
			3'd4: s = SECTOR_4;
			3'd5: s = SECTOR_3;
			3'd6: s = SECTOR_5;
			default: s = SECTOR_NONE;
		endcase
		return s;
	endfunction

endpackage

// File: sv/svpwm_if.sv
// Valid/ready channel interfaces for the SVPWM duty calculator.
// No dependencies.
interface svpwm_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] alpha_voltage;
	logic [15:0] beta_voltage;
	logic [15:0] bus_voltage;

	modport source(output valid, alpha_voltage, beta_voltage, bus_voltage, input ready);
	modport sink(input valid, alpha_voltage, beta_voltage, bus_voltage, output ready);
endinterface

interface svpwm_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] phase_a_duty;
	logic [15:0] phase_b_duty;
	logic [15:0] phase_c_duty;
	logic [2:0]  sector_number;
	logic        bus_too_low;

	modport source(output valid, phase_a_duty, phase_b_duty, phase_c_duty, sector_number,
		bus_too_low, input ready);
	modport sink(input valid, phase_a_duty, phase_b_duty, phase_c_duty, sector_number,
		bus_too_low, output ready);
endinterface

// File: sv/svpwm_div.sv
// Pipelined restoring divider: two numerators over one shared denominator,
// one quotient bit per stage, sideband carried alongside. No package needed.
module svpwm_div #(
	parameter int NUM_W  = 32,
	parameter int DEN_W  = 16,
	parameter int Q_W    = 32,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [NUM_W-1:0]  num0,
	input  logic [NUM_W-1:0]  num1,
	input  logic [DEN_W-1:0]  den,
	input  logic [SIDE_W-1:0] side,
	output logic              out_valid,
	output logic [Q_W-1:0]    quo0,
	output logic [Q_W-1:0]    quo1,
	output logic [SIDE_W-1:0] out_side
);
	// requires num < den * 2**Q_W
	localparam int W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

	logic [W-1:0]      rem0 [Q_W+1];
	logic [W-1:0]      rem1 [Q_W+1];
	logic [Q_W-1:0]    q0   [Q_W+1];
	logic [Q_W-1:0]    q1   [Q_W+1];
	logic [DEN_W-1:0]  d    [Q_W+1];
	logic [SIDE_W-1:0] sd   [Q_W+1];
	logic              v    [Q_W+1];

	assign rem0[0] = W'(num0);
	assign rem1[0] = W'(num1);
	assign q0[0]   = '0;
	assign q1[0]   = '0;
	assign d[0]    = den;
	assign sd[0]   = side;
	assign v[0]    = in_valid;

	for (genvar k = 0; k < Q_W; k++) begin : g_stage
		logic [W-1:0] trial;
		logic         ge0;
		logic         ge1;

		assign trial = W'(d[k]) << (Q_W - 1 - k);
		assign ge0   = rem0[k] >= trial;
		assign ge1   = rem1[k] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v[k+1] <= 1'b0;
			end else if (en) begin
				v[k+1] <= v[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem0[k+1] <= ge0 ? rem0[k] - trial : rem0[k];
				rem1[k+1] <= ge1 ? rem1[k] - trial : rem1[k];
				q0[k+1]   <= {q0[k][Q_W-2:0], ge0};
				q1[k+1]   <= {q1[k][Q_W-2:0], ge1};
				d[k+1]    <= d[k];
				sd[k+1]   <= sd[k];
			end
		end
	end

	assign out_valid = v[Q_W];
	assign quo0      = q0[Q_W];
	assign quo1      = q1[Q_W];
	assign out_side  = sd[Q_W];
endmodule

// File: sv/svpwm_duty_calculator.sv
// SVPWM duty calculator, fully pipelined from input transfer to result (input stage,
// 32 normalizing divide stages, 2 projection stages, 17 + 17 rescale divide stages,
// 2 select/output stages). Throughput one transfer per cycle; the whole pipe
// freezes while the output holds an untaken result.
// Reset (arst_n low, asynchronous) clears all valid bits and loads the register defaults.
`include "assert_macros.svh"
module svpwm_duty_calculator (
	input  logic                         clk,
	input  logic                         arst_n,
	svpwm_in_if.sink                     vec_in,
	svpwm_out_if.source                  duty_out,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [svpwm_pkg::APB_AW-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import svpwm_pkg::*;

	// ---------------------------------------------------------------
	// Configuration registers (written only while the pipe is empty; the block does not enforce it)
	// ---------------------------------------------------------------
	logic [15:0] modulation_limit_q;
	logic [15:0] min_bus_voltage_q;
	logic        apb_wr;

	assign pready = 1'b1;
	assign apb_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulation_limit_q <= MOD_LIMIT_RST;
			min_bus_voltage_q  <= MIN_BUS_RST;
		end else if (apb_wr) begin
			if (paddr == ADDR_MOD_LIMIT) modulation_limit_q <= pwdata[15:0];
			if (paddr == ADDR_MIN_BUS)   min_bus_voltage_q  <= pwdata[15:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == ADDR_MOD_LIMIT) prdata = {16'd0, modulation_limit_q};
		if (paddr == ADDR_MIN_BUS)   prdata = {16'd0, min_bus_voltage_q};
	end

	// ---------------------------------------------------------------
	// Global stall: every stage moves when the output slot is free
	// or being taken. Bubbles travel with their cleared valid bits.
	// ---------------------------------------------------------------
	logic en;
	logic v_s5;

	assign en           = !v_s5 || duty_out.ready;
	assign vec_in.ready = en;

	// ---------------------------------------------------------------
	// Stage 1: bus check, |alpha|*sqrt3 and |beta|*sqrt3 (magnitudes,
	// so the divide truncates toward zero)
	// ---------------------------------------------------------------
	logic [15:0] abs_a;
	logic [15:0] abs_b;
	logic        v_s1;
	logic [31:0] prod_a_s1;
	logic [31:0] prod_b_s1;
	logic [15:0] bus_s1;
	side_a_t     side_a_s1;

	assign abs_a = vec_in.alpha_voltage[15] ? 16'(-vec_in.alpha_voltage) : vec_in.alpha_voltage;
	assign abs_b = vec_in.beta_voltage[15]  ? 16'(-vec_in.beta_voltage)  : vec_in.beta_voltage;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= vec_in.valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_a_s1         <= 32'({16'd0, abs_a} * 32'(SQRT3_Q16));
			prod_b_s1         <= 32'({16'd0, abs_b} * 32'(SQRT3_Q16));
			bus_s1            <= vec_in.bus_voltage;
			side_a_s1.bus_low <= (vec_in.bus_voltage == 16'd0) ||
				(vec_in.bus_voltage < min_bus_voltage_q);
			side_a_s1.neg_a   <= vec_in.alpha_voltage[15];
			side_a_s1.neg_b   <= vec_in.beta_voltage[15];
		end
	end

	// ---------------------------------------------------------------
	// Normalize: va, vb = v * sqrt3 / bus. A zero bus only occurs with
	// bus_low set, and that result is discarded downstream.
	// ---------------------------------------------------------------
	logic                 v_da;
	logic [31:0]          qa;
	logic [31:0]          qb;
	logic [$bits(side_a_t)-1:0] side_a_vec;
	side_a_t              side_a_da;

	svpwm_div #(
		.NUM_W (32),
		.DEN_W (16),
		.Q_W   (32),
		.SIDE_W($bits(side_a_t))
	) u_div_norm (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s1),
		.num0     (prod_a_s1),
		.num1     (prod_b_s1),
		.den      (bus_s1),
		.side     (side_a_s1),
		.out_valid(v_da),
		.quo0     (qa),
		.quo1     (qb),
		.out_side (side_a_vec)
	);

	assign side_a_da = side_a_vec;

	// ---------------------------------------------------------------
	// Stage 2: sqrt3/2 * |va|
	// ---------------------------------------------------------------
	logic        v_s2;
	logic [48:0] m_s2;
	logic [31:0] qb_s2;
	side_a_t     side_a_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_da;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s2      <= 49'(qa) * 49'(SQRT3_HALF_Q16);
			qb_s2     <= qb;
			side_a_s2 <= side_a_da;
		end
	end

	// ---------------------------------------------------------------
	// Stage 3: projections u1..u3, sector, active times t1/t2 and sum
	// ---------------------------------------------------------------
	logic [32:0]        p_mag;
	logic signed [35:0] p_v;
	logic signed [35:0] vb_v;
	logic signed [35:0] vbh_v;
	logic signed [35:0] u1;
	logic signed [35:0] u2;
	logic signed [35:0] u3;
	logic signed [35:0] t1_v;
	logic signed [35:0] t2_v;
	logic [2:0]         sector_v;

	assign p_mag = m_s2[48:16];
	assign p_v   = side_a_s2.neg_a ? -36'(p_mag) : 36'(p_mag);
	assign vb_v  = side_a_s2.neg_b ? -36'(qb_s2) : 36'(qb_s2);
	assign vbh_v = side_a_s2.neg_b ? -36'(qb_s2 >> 1) : 36'(qb_s2 >> 1);
	assign u1    = vb_v;
	assign u2    = p_v - vbh_v;
	assign u3    = -p_v - vbh_v;

	assign sector_v = sector_of_code({u3 > 0, u2 > 0, u1 > 0});

	always_comb begin
		unique case (sector_v)
			SECTOR_1: begin t1_v = u2;  t2_v = u1;  end
			SECTOR_2: begin t1_v = -u2; t2_v = -u3; end
			SECTOR_3: begin t1_v = u1;  t2_v = u3;  end
			SECTOR_4: begin t1_v = -u1; t2_v = -u2; end
			SECTOR_5: begin t1_v = u3;  t2_v = u2;  end
			SECTOR_6: begin t1_v = -u3; t2_v = -u1; end
			default:  begin t1_v = '0;  t2_v = '0;  end
		endcase
	end

	// t1, t2 are never negative for a valid sector
	logic        v_s3;
	logic [34:0] t1_s3;
	logic [34:0] t2_s3;
	logic [35:0] sum_s3;
	logic [2:0]  sector_s3;
	logic        bus_low_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t1_s3      <= t1_v[34:0];
			t2_s3      <= t2_v[34:0];
			sum_s3     <= 36'(t1_v[34:0]) + 36'(t2_v[34:0]);
			sector_s3  <= sector_v;
			bus_low_s3 <= side_a_s2.bus_low;
		end
	end

	// ---------------------------------------------------------------
	// Rescale to unit sum: t * 1.0 / s, used only when s > 1.0
	// (otherwise t1, t2 already fit in 17 bits)
	// ---------------------------------------------------------------
	side_b_t              side_b_in;
	logic                 v_db;
	logic [16:0]          qb0;
	logic [16:0]          qb1;
	logic [$bits(side_b_t)-1:0] side_b_vec;
	side_b_t              side_b_db;

	assign side_b_in.big     = sum_s3 > 36'(Q16_ONE);
	assign side_b_in.t1      = t1_s3[16:0];
	assign side_b_in.t2      = t2_s3[16:0];
	assign side_b_in.sector  = sector_s3;
	assign side_b_in.bus_low = bus_low_s3;

	svpwm_div #(
		.NUM_W (51),
		.DEN_W (36),
		.Q_W   (17),
		.SIDE_W($bits(side_b_t))
	) u_div_unit (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s3),
		.num0     ({t1_s3, 16'd0}),
		.num1     ({t2_s3, 16'd0}),
		.den      (sum_s3),
		.side     (side_b_in),
		.out_valid(v_db),
		.quo0     (qb0),
		.quo1     (qb1),
		.out_side (side_b_vec)
	);

	assign side_b_db = side_b_vec;

	// ---------------------------------------------------------------
	// Stage 4: pick scaled times, compare against limit, t * limit
	// ---------------------------------------------------------------
	logic [16:0] t1_n;
	logic [16:0] t2_n;
	logic [16:0] lim;
	logic [17:0] sum_n;

	assign t1_n  = side_b_db.big ? qb0 : side_b_db.t1;
	assign t2_n  = side_b_db.big ? qb1 : side_b_db.t2;
	assign lim   = {modulation_limit_q, 1'b0};
	assign sum_n = 18'(t1_n) + 18'(t2_n);

	logic        v_s4;
	logic [33:0] p1_s4;
	logic [33:0] p2_s4;
	logic [17:0] sum_s4;
	side_c_t     side_c_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_db;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p1_s4             <= 34'(t1_n) * 34'(lim);
			p2_s4             <= 34'(t2_n) * 34'(lim);
			sum_s4            <= sum_n;
			side_c_s4.big     <= sum_n > 18'(lim);
			side_c_s4.t1      <= t1_n;
			side_c_s4.t2      <= t2_n;
			side_c_s4.sector  <= side_b_db.sector;
			side_c_s4.bus_low <= side_b_db.bus_low;
		end
	end

	// ---------------------------------------------------------------
	// Rescale to modulation limit: t * lim / s, used when s > lim
	// ---------------------------------------------------------------
	logic                 v_dc;
	logic [16:0]          qc0;
	logic [16:0]          qc1;
	logic [$bits(side_c_t)-1:0] side_c_vec;
	side_c_t              side_c_dc;

	svpwm_div #(
		.NUM_W (34),
		.DEN_W (18),
		.Q_W   (17),
		.SIDE_W($bits(side_c_t))
	) u_div_limit (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s4),
		.num0     (p1_s4),
		.num1     (p2_s4),
		.den      (sum_s4),
		.side     (side_c_s4),
		.out_valid(v_dc),
		.quo0     (qc0),
		.quo1     (qc1),
		.out_side (side_c_vec)
	);

	assign side_c_dc = side_c_vec;

	// ---------------------------------------------------------------
	// Stage 5 (output register): zero-time split, phase roles, Q1.15
	// ---------------------------------------------------------------
	logic [16:0] t1_f;
	logic [16:0] t2_f;
	logic [17:0] sum_f;
	logic [17:0] half;
	logic [17:0] dmax;
	logic [17:0] dmid;
	logic [17:0] dmin;
	logic [15:0] qmax;
	logic [15:0] qmid;
	logic [15:0] qmin;
	logic [15:0] da;
	logic [15:0] db;
	logic [15:0] dc;
	logic [2:0]  sec_o;

	// sum is at most 1.0 here, so every duty lands in 0..1.0 without clamping
	assign t1_f  = side_c_dc.big ? qc0 : side_c_dc.t1;
	assign t2_f  = side_c_dc.big ? qc1 : side_c_dc.t2;
	assign sum_f = 18'(t1_f) + 18'(t2_f);
	assign half  = (Q16_ONE - sum_f) >> 1;
	assign dmax  = sum_f + half;
	assign dmid  = 18'(t2_f) + half;
	assign dmin  = half;
	assign qmax  = dmax[16:1];
	assign qmid  = dmid[16:1];
	assign qmin  = dmin[16:1];

	always_comb begin
		sec_o = side_c_dc.sector;
		unique case (side_c_dc.sector)
			SECTOR_1: begin da = qmax; db = qmid; dc = qmin; end
			SECTOR_2: begin da = qmid; db = qmax; dc = qmin; end
			SECTOR_3: begin da = qmin; db = qmax; dc = qmid; end
			SECTOR_4: begin da = qmin; db = qmid; dc = qmax; end
			SECTOR_5: begin da = qmid; db = qmin; dc = qmax; end
			SECTOR_6: begin da = qmax; db = qmin; dc = qmid; end
			default:  begin da = HALF_Q15; db = HALF_Q15; dc = HALF_Q15; end
		endcase
		if (side_c_dc.bus_low) begin
			da    = '0;
			db    = '0;
			dc    = '0;
			sec_o = SECTOR_NONE;
		end
	end

	logic [15:0] da_s5;
	logic [15:0] db_s5;
	logic [15:0] dc_s5;
	logic [2:0]  sector_s5;
	logic        bus_low_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (en) v_s5 <= v_dc;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			da_s5      <= da;
			db_s5      <= db;
			dc_s5      <= dc;
			sector_s5  <= sec_o;
			bus_low_s5 <= side_c_dc.bus_low;
		end
	end

	assign duty_out.valid         = v_s5;
	assign duty_out.phase_a_duty  = da_s5;
	assign duty_out.phase_b_duty  = db_s5;
	assign duty_out.phase_c_duty  = dc_s5;
	assign duty_out.sector_number = sector_s5;
	assign duty_out.bus_too_low   = bus_low_s5;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	`SVPWM_IMPLIES(a_bus_low_zero, clk, arst_n, duty_out.valid && duty_out.bus_too_low, duty_out.phase_a_duty == '0 && duty_out.phase_b_duty == '0 && duty_out.phase_c_duty == '0 && duty_out.sector_number == SECTOR_NONE)
	`SVPWM_IMPLIES(a_invalid_half, clk, arst_n, duty_out.valid && !duty_out.bus_too_low && duty_out.sector_number == SECTOR_NONE, duty_out.phase_a_duty == HALF_Q15 && duty_out.phase_b_duty == HALF_Q15 && duty_out.phase_c_duty == HALF_Q15)
	`SVPWM_IMPLIES(a_max_phase_half, clk, arst_n, duty_out.valid && duty_out.sector_number != SECTOR_NONE, duty_out.phase_a_duty >= HALF_Q15 || duty_out.phase_b_duty >= HALF_Q15 || duty_out.phase_c_duty >= HALF_Q15)
	`SVPWM_ASSERT(a_duty_range, clk, arst_n, !duty_out.valid || (duty_out.phase_a_duty <= 16'd32768 && duty_out.phase_b_duty <= 16'd32768 && duty_out.phase_c_duty <= 16'd32768))
endmodule

// File: dv/svpwm_duty_calculator_test.sv
// Self-checking test for svpwm_duty_calculator: directed corners and random
// alpha/beta/bus vectors, random stalls on both channels, APB config phases.
// Depends on svpwm_pkg and svpwm_if.
module svpwm_duty_calculator_test;
	timeunit 1ns;
	timeprecision 1ps;
	import svpwm_pkg::*;

	typedef struct packed {
		logic [15:0] a;
		logic [15:0] b;
		logic [15:0] c;
		logic [2:0]  sector;
		logic        low;
	} duty_t;

	int mismatches = 0;

	task automatic report(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		mismatches++;
	endtask

	// Duty predictor with its own register copies.
	class duty_scoreboard;
		logic [15:0] mod_limit = MOD_LIMIT_RST;
		logic [15:0] min_bus = MIN_BUS_RST;
		duty_t pending[$];

		function longint clamp_q15(input longint d);
			if (d < 0) d = 0;
			if (d > 65536) d = 65536;
			return d / 2;
		endfunction

		function duty_t predict(input logic [15:0] al, input logic [15:0] be,
			input logic [15:0] bu);
			duty_t r;
			longint alpha, beta, bus, va, vb, u1, u2, u3, t1, t2, s, lim, half;
			longint dmax, dmid, dmin, da, db, dc;
			logic [2:0] code, sec;
			alpha = longint'($signed(al));
			beta = longint'($signed(be));
			bus = longint'(bu);
			r = '0;
			if (bus == 0 || bus < longint'(min_bus)) begin
				r.low = 1'b1;
				return r;
			end
			va = (alpha * 113512) / bus;
			vb = (beta * 113512) / bus;
			u1 = vb;
			u2 = (56756 * va) / 65536 - vb / 2;
			u3 = (-56756 * va) / 65536 - vb / 2;
			code = {u3 > 0, u2 > 0, u1 > 0};
			case (code)
				3'd1: sec = SECTOR_2;
				3'd2: sec = SECTOR_6;
				3'd3: sec = SECTOR_1;
				3'd4: sec = SECTOR_4;
				3'd5: sec = SECTOR_3;
				3'd6: sec = SECTOR_5;
				default: sec = SECTOR_NONE;
			endcase
			case (sec)
				SECTOR_1: begin t1 = u2; t2 = u1; end
				SECTOR_2: begin t1 = -u2; t2 = -u3; end
				SECTOR_3: begin t1 = u1; t2 = u3; end
				SECTOR_4: begin t1 = -u1; t2 = -u2; end
				SECTOR_5: begin t1 = u3; t2 = u2; end
				SECTOR_6: begin t1 = -u3; t2 = -u1; end
				default: begin
					r.a = HALF_Q15;
					r.b = HALF_Q15;
					r.c = HALF_Q15;
					return r;
				end
			endcase
			s = t1 + t2;
			if (s > 65536) begin
				t1 = (t1 * 65536) / s;
				t2 = (t2 * 65536) / s;
			end
			lim = longint'(mod_limit) * 2;
			s = t1 + t2;
			if (s > lim) begin
				t1 = (t1 * lim) / s;
				t2 = (t2 * lim) / s;
			end
			half = (65536 - t1 - t2) / 2;
			dmax = t1 + t2 + half;
			dmid = t2 + half;
			dmin = half;
			case (sec)
				SECTOR_1: begin da = dmax; db = dmid; dc = dmin; end
				SECTOR_2: begin da = dmid; db = dmax; dc = dmin; end
				SECTOR_3: begin da = dmin; db = dmax; dc = dmid; end
				SECTOR_4: begin da = dmin; db = dmid; dc = dmax; end
				SECTOR_5: begin da = dmid; db = dmin; dc = dmax; end
				default: begin da = dmax; db = dmin; dc = dmid; end
			endcase
			r.a = 16'(clamp_q15(da));
			r.b = 16'(clamp_q15(db));
			r.c = 16'(clamp_q15(dc));
			r.sector = sec;
			return r;
		endfunction

		function void note_input(input logic [15:0] al, input logic [15:0] be,
			input logic [15:0] bu);
			pending.push_back(predict(al, be, bu));
		endfunction

		task check_result(input duty_t got);
			duty_t want;
			if (pending.size() == 0) begin
				report("unexpected result", 0, 0);
				return;
			end
			want = pending.pop_front();
			if (got.a !== want.a) report("phase_a_duty", int'(got.a), int'(want.a));
			if (got.b !== want.b) report("phase_b_duty", int'(got.b), int'(want.b));
			if (got.c !== want.c) report("phase_c_duty", int'(got.c), int'(want.c));
			if (got.sector !== want.sector)
				report("sector_number", int'(got.sector), int'(want.sector));
			if (got.low !== want.low) report("bus_too_low", int'(got.low), int'(want.low));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	svpwm_in_if vec_ch();
	svpwm_out_if duty_ch();

	svpwm_duty_calculator uut (
		.clk(clk), .arst_n(arst_n), .vec_in(vec_ch.sink), .duty_out(duty_ch.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #6 clk = ~clk;

	duty_scoreboard duty_sb = new();

	// idle_pct: percentage of cycles each side idles; zero gives a clean stretch
	int in_idle_pct = 34;
	int out_idle_pct = 34;
	int hold_off = 0;     // long receiver stall, counted in the receiver process
	bit stim_done = 0;

	initial begin
		vec_ch.valid = 1'b0;
		vec_ch.alpha_voltage = '0;
		vec_ch.beta_voltage = '0;
		vec_ch.bus_voltage = '0;
		duty_ch.ready = 1'b0;
	end

	// Receiver: random ready, optional long hold-off; checks each output transfer.
	always @(posedge clk) begin
		if (arst_n && duty_ch.valid && duty_ch.ready)
			duty_sb.check_result({duty_ch.phase_a_duty, duty_ch.phase_b_duty,
				duty_ch.phase_c_duty, duty_ch.sector_number, duty_ch.bus_too_low});
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			duty_ch.ready <= 1'b0;
		end else
			duty_ch.ready <= ($urandom_range(99) >= out_idle_pct);
	end

	// APB write: setup then access cycle; register latches on the access edge.
	task automatic reg_write(input logic [APB_AW-1:0] addr, input logic [15:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= {16'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_MOD_LIMIT) duty_sb.mod_limit = val;
		else duty_sb.min_bus = val;
	endtask

	// One input transfer, with a random gap before it; valid stays high across
	// back-to-back transfers.
	task automatic send_vector(input logic [15:0] al, input logic [15:0] be,
		input logic [15:0] bu);
		while ($urandom_range(99) < in_idle_pct) begin
			vec_ch.valid <= 1'b0;
			@(posedge clk);
		end
		vec_ch.valid <= 1'b1;
		vec_ch.alpha_voltage <= al;
		vec_ch.beta_voltage <= be;
		vec_ch.bus_voltage <= bu;
		@(posedge clk);
		while (!vec_ch.ready) @(posedge clk);
		duty_sb.note_input(al, be, bu);
	endtask

	task automatic drain();
		vec_ch.valid <= 1'b0;
		while (duty_sb.pending.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	// Random vector: mostly realistic magnitudes up to a random bus voltage, some raw noise.
	task automatic send_random();
		logic [15:0] bu;
		int mag;
		case ($urandom_range(9))
			0: send_vector(16'($urandom), 16'($urandom), 16'($urandom));
			1: send_vector(16'($urandom), 16'($urandom), 16'($urandom_range(40)));
			default: begin
				bu = 16'($urandom_range(65535, 256));
				mag = $urandom_range(int'(bu));
				send_vector(16'($urandom_range(2 * mag) - mag),
					16'($urandom_range(2 * mag) - mag), bu);
			end
		endcase
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed corners at reset settings: zero vector, every sector,
		// field extremes, bus zero, bus just below and at threshold.
		send_vector(16'd0, 16'd0, 16'd6144);
		send_vector(16'd256, 16'd100, 16'd6144);
		send_vector(16'd0, 16'd512, 16'd6144);
		send_vector(16'hFF00, 16'd100, 16'd6144);
		send_vector(16'hFF00, 16'hFF9C, 16'd6144);
		send_vector(16'd0, 16'hFE00, 16'd6144);
		send_vector(16'd256, 16'hFF9C, 16'd6144);
		send_vector(16'h7FFF, 16'h7FFF, 16'hFFFF);
		send_vector(16'h8000, 16'h8000, 16'hFFFF);
		send_vector(16'h7FFF, 16'h8000, 16'd26);
		send_vector(16'h8000, 16'h7FFF, 16'd27);
		send_vector(16'd300, 16'd300, 16'd25);
		send_vector(16'd300, 16'd300, 16'd0);
		send_vector(16'd1, 16'd0, 16'd1);
		send_vector(16'hFFFF, 16'hFFFF, 16'hFFFF);
		drain();

		// Register phases, extremes included; bus threshold zero exercises bus zero.
		reg_write(ADDR_MOD_LIMIT, 16'd32768);
		reg_write(ADDR_MIN_BUS, 16'd0);
		send_vector(16'h7FFF, 16'h0000, 16'd0);
		send_vector(16'h7FFF, 16'h0000, 16'd1);
		repeat (200) send_random();
		drain();

		reg_write(ADDR_MOD_LIMIT, 16'd0);
		reg_write(ADDR_MIN_BUS, 16'hFFFF);
		repeat (150) send_random();
		drain();

		reg_write(ADDR_MOD_LIMIT, 16'hFFFF);
		reg_write(ADDR_MIN_BUS, 16'd1000);
		repeat (150) send_random();
		drain();

		reg_write(ADDR_MOD_LIMIT, 16'd16384);
		reg_write(ADDR_MIN_BUS, 16'd26);
		// Clean stretch: no idling on either side.
		in_idle_pct = 0;
		out_idle_pct = 0;
		repeat (300) send_random();
		// Back-pressure: receiver stalls long while the sender keeps offering.
		hold_off = 300;
		repeat (200) send_random();
		in_idle_pct = 34;
		out_idle_pct = 34;
		drain();

		reg_write(ADDR_MOD_LIMIT, 16'($urandom_range(32768)));
		reg_write(ADDR_MIN_BUS, 16'($urandom_range(2000)));
		repeat (400) send_random();
		drain();
		stim_done = 1;
	end

	initial begin
		wait (stim_done);
		if (mismatches == 0 && duty_sb.pending.size() == 0)
			$display("svpwm_duty_calculator regression: pass");
		else
			$display("svpwm_duty_calculator regression: fail");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#5ms;
		$display("svpwm_duty_calculator regression: fail");
		$finish;
	end
endmodule

// File: files.f
+incdir+sv
sv/svpwm_pkg.sv
sv/svpwm_if.sv
sv/svpwm_div.sv
sv/svpwm_duty_calculator.sv
dv/svpwm_duty_calculator_test.sv
